### rtl/c3rb_pkg.sv
// ----------------------------------------------------------------------------
// c3rb_pkg: shared types and constants
// Register indexes, fixed field widths and the job control struct used by
// the front end, the filter back end and the top level.
// ----------------------------------------------------------------------------
package c3rb_pkg;

	// Fixed field widths, row limit and kernel size.
	localparam int ROW_BITS    = 12;
	localparam int HEIGHT_BITS = 13;
	localparam int ROW_LIMIT   = 4096;
	localparam int WEIGHT_BITS = 16;
	localparam int TAPS        = 9;
	localparam int KSIZE       = 3;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 64;
	localparam int SRC_WIDTH_BITS = 11;
	localparam int SRC_HEIGHT_BITS = 13;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SOURCE_WIDTH   = 3'd0,
		REG_SOURCE_HEIGHT  = 3'd1,
		REG_OUTPUT_WIDTH   = 3'd2,
		REG_OUTPUT_HEIGHT  = 3'd3,
		REG_WEIGHTS_TOP    = 3'd4,
		REG_WEIGHTS_MIDDLE = 3'd5,
		REG_WEIGHT_LAST    = 3'd6
	} cfg_reg_t;

	// Reset values of the registers.
	localparam logic [SRC_WIDTH_BITS-1:0]  RST_SOURCE_WIDTH  = 11'd1024;
	localparam logic [SRC_HEIGHT_BITS-1:0] RST_SOURCE_HEIGHT = 13'd1024;
	localparam logic [SRC_WIDTH_BITS-1:0]  RST_OUTPUT_WIDTH  = 11'd1024;
	localparam logic [SRC_HEIGHT_BITS-1:0] RST_OUTPUT_HEIGHT = 13'd1024;
	localparam logic [CFG_DATA_BITS-1:0]   RST_WEIGHTS_TOP   = 64'd0;
	localparam logic [CFG_DATA_BITS-1:0]   RST_WEIGHTS_MID   = 64'd16384;
	localparam logic [WEIGHT_BITS-1:0]     RST_WEIGHT_LAST   = 16'd0;

	typedef struct packed {
		logic last_of_run;
		logic frame_end;
	} job_ctl_t;

endpackage

### rtl/c3rb_front.sv
// ----------------------------------------------------------------------------
// c3rb_front: pixel intake and job generation
// Tracks the raster position, keeps the two line stores and the 3x3 window,
// and turns each accepted pixel into zero to four jobs, one per non-full cycle.
// ----------------------------------------------------------------------------
module c3rb_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    restart,
	input  logic [CW:0]                             eff_width,
	input  logic [c3rb_pkg::HEIGHT_BITS-1:0]        eff_height,
	input  logic [CW:0]                             out_width,
	input  logic [c3rb_pkg::HEIGHT_BITS-1:0]        out_height,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [PIXEL_BITS-1:0]                   sample,
	input  logic                                    fifo_full,
	output logic                                    push,
	output logic [c3rb_pkg::TAPS*PIXEL_BITS-1:0]    job_taps,
	output logic [CW-1:0]                           job_column,
	output logic [c3rb_pkg::ROW_BITS-1:0]           job_line,
	output c3rb_pkg::job_ctl_t                      job_ctl
);

	localparam int RB = c3rb_pkg::ROW_BITS;
	localparam int K  = c3rb_pkg::KSIZE;

	logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] rd_old_q, rd_new_q;
	logic [PIXEL_BITS-1:0] win_q [K][K];

	logic [CW-1:0] col_q, col_next, raddr;
	logic [RB-1:0] row_q;
	logic [CW-1:0] x_s1;
	logic [RB-1:0] r_s1;
	logic [3:0]    mask_s1, new_mask, sel, rest;

	logic accept, last_col, last_row;
	logic rv0, rv1, cv0, cv1, rin0, rin1, cin0, cin1;
	logic [CW-1:0] cc0;
	logic [RB-1:0] rr0;
	logic sel_row, sel_col;

	// Window row or column for one tap: clamp the source coordinate to the
	// frame, then map it onto the three newest rows or columns.
	function automatic logic [1:0] win_index(input int center, input int offs,
			input int limit, input int newest);
		int s;
		int w;
		s = center + offs - 1;
		if (s < 0) s = 0;
		if (s > limit - 1) s = limit - 1;
		w = s - newest + 2;
		if (w < 0) w = 0;
		if (w > 2) w = 2;
		return w[1:0];
	endfunction

	assign accept   = in_valid & in_ready;
	assign last_col = ({1'b0, col_q} == eff_width - 1'b1);
	assign last_row = ({1'b0, row_q} == eff_height - 1'b1);
	assign col_next = last_col ? '0 : col_q + 1'b1;
	assign raddr    = restart ? '0 : (accept ? col_next : col_q);

	// Line stores. The read for the next pixel is registered ahead of it;
	// with a one-pixel-wide source the same entry is bypassed.
	always_ff @(posedge clk) begin
		if (accept) begin
			older_mem[col_q] <= rd_new_q;
			newer_mem[col_q] <= sample;
		end
		if (accept && raddr == col_q) begin
			rd_old_q <= rd_new_q;
			rd_new_q <= sample;
		end else begin
			rd_old_q <= older_mem[raddr];
			rd_new_q <= newer_mem[raddr];
		end
	end

	// Which outputs this pixel completes.
	assign rv0  = (row_q != '0);
	assign rv1  = last_row;
	assign cv0  = (col_q != '0);
	assign cv1  = last_col;
	assign rr0  = row_q - 1'b1;
	assign cc0  = col_q - 1'b1;
	assign rin0 = ({1'b0, rr0} < out_height);
	assign rin1 = ({1'b0, row_q} < out_height);
	assign cin0 = ({1'b0, cc0} < out_width);
	assign cin1 = ({1'b0, col_q} < out_width);

	assign new_mask[0] = rv0 & cv0 & rin0 & cin0;
	assign new_mask[1] = rv0 & cv1 & rin0 & cin1;
	assign new_mask[2] = rv1 & cv0 & rin1 & cin0;
	assign new_mask[3] = rv1 & cv1 & rin1 & cin1;

	// Jobs leave lowest slot first: upper row before lower, left before right.
	assign sel      = mask_s1 & (~mask_s1 + 4'd1);
	assign rest     = mask_s1 & ~sel;
	assign push     = (mask_s1 != '0) & ~fifo_full;
	assign in_ready = (mask_s1 == '0) | (push & (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			x_s1    <= '0;
			r_s1    <= '0;
			mask_s1 <= '0;
			for (int i = 0; i < K; i++) begin
				for (int j = 0; j < K; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				col_q <= col_next;
				if (last_col) begin
					row_q <= last_row ? '0 : row_q + 1'b1;
				end
			end
			if (accept) begin
				x_s1    <= col_q;
				r_s1    <= row_q;
				mask_s1 <= new_mask;
				for (int i = 0; i < K; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= rd_old_q;
				win_q[1][2] <= rd_new_q;
				win_q[2][2] <= sample;
			end else if (push) begin
				mask_s1 <= rest;
			end
		end
	end

	assign sel_row    = sel[2] | sel[3];
	assign sel_col    = sel[1] | sel[3];
	assign job_column = sel_col ? x_s1 : x_s1 - 1'b1;
	assign job_line   = sel_row ? r_s1 : r_s1 - 1'b1;

	assign job_ctl.last_of_run = (rest == '0);
	assign job_ctl.frame_end   = ({1'b0, job_column} == out_width - 1'b1) &&
		({1'b0, job_line} == out_height - 1'b1);

	always_comb begin
		logic [1:0] wy [K];
		logic [1:0] wx [K];
		for (int k = 0; k < K; k++) begin
			wy[k] = win_index(int'(job_line), k, int'(eff_height), int'(r_s1));
			wx[k] = win_index(int'(job_column), k, int'(eff_width), int'(x_s1));
		end
		for (int ky = 0; ky < K; ky++) begin
			for (int kx = 0; kx < K; kx++) begin
				job_taps[(ky*K+kx)*PIXEL_BITS +: PIXEL_BITS] = win_q[wy[ky]][wx[kx]];
			end
		end
	end

endmodule

### rtl/c3rb_fifo.sv
// ----------------------------------------------------------------------------
// c3rb_fifo: job queue
// Small first-in first-out store between the front end and the filter,
// absorbing the bursts of up to four jobs that one pixel can cause.
// ----------------------------------------------------------------------------
module c3rb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [AW:0]      count_q;

	assign full     = (count_q == (AW+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("job queue read while empty");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("job queue count did not follow a write");

endmodule

### rtl/c3rb_back.sv
// ----------------------------------------------------------------------------
// c3rb_back: filter arithmetic
// Nine multiplies, a two-level add, rounding, shift and saturation, then the
// output register. The whole pipe advances when the output can move.
// ----------------------------------------------------------------------------
module c3rb_back #(
	parameter int MAX_WIDTH            = 1024,
	parameter int PIXEL_BITS           = 16,
	parameter int WEIGHT_FRACTION_BITS = 14,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic [c3rb_pkg::TAPS*c3rb_pkg::WEIGHT_BITS-1:0]      weights,
	input  logic                                                 fifo_empty,
	output logic                                                 pop,
	input  logic [c3rb_pkg::TAPS*PIXEL_BITS-1:0]                 job_taps,
	input  logic [CW-1:0]                                        job_column,
	input  logic [c3rb_pkg::ROW_BITS-1:0]                        job_line,
	input  c3rb_pkg::job_ctl_t                                   job_ctl,
	output logic                                                 out_valid,
	input  logic                                                 out_ready,
	output logic [PIXEL_BITS-1:0]                                value,
	output logic [CW-1:0]                                        column,
	output logic [c3rb_pkg::ROW_BITS-1:0]                        line,
	output logic                                                 last_of_run,
	output logic                                                 frame_end
);

	localparam int WB = c3rb_pkg::WEIGHT_BITS;
	localparam int NT = c3rb_pkg::TAPS;
	localparam int PB = PIXEL_BITS + WB;
	localparam int GB = PB + 2;
	localparam int SW = PB + 4;
	localparam logic signed [SW-1:0] PMAX = {{(SW-PIXEL_BITS+1){1'b0}}, {(PIXEL_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] PMIN = ~PMAX;
	localparam logic signed [SW-1:0] RND  = {{(SW-1){1'b0}}, 1'b1} << (WEIGHT_FRACTION_BITS-1);

	logic en;

	logic                          valid_s1, valid_s2, out_valid_q;
	logic signed [PB-1:0]          prod_s1 [NT];
	logic signed [GB-1:0]          part_s2 [3];
	logic [CW-1:0]                 col_s1, col_s2, column_q;
	logic [c3rb_pkg::ROW_BITS-1:0] line_s1, line_s2, line_q;
	c3rb_pkg::job_ctl_t            ctl_s1, ctl_s2, ctl_q;
	logic [PIXEL_BITS-1:0]         value_q;

	logic signed [SW-1:0] sum, rounded, shifted, sat;

	assign en  = ~out_valid_q | out_ready;
	assign pop = en & ~fifo_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= ~fifo_empty;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NT; k++) begin
				prod_s1[k] <= $signed(job_taps[k*PIXEL_BITS +: PIXEL_BITS]) *
					$signed(weights[k*WB +: WB]);
			end
			col_s1  <= job_column;
			line_s1 <= job_line;
			ctl_s1  <= job_ctl;
			for (int g = 0; g < 3; g++) begin
				part_s2[g] <= GB'(prod_s1[3*g]) + GB'(prod_s1[3*g+1]) + GB'(prod_s1[3*g+2]);
			end
			col_s2   <= col_s1;
			line_s2  <= line_s1;
			ctl_s2   <= ctl_s1;
			value_q  <= sat[PIXEL_BITS-1:0];
			column_q <= col_s2;
			line_q   <= line_s2;
			ctl_q    <= ctl_s2;
		end
	end

	// Round half up, floor shift, clip to the pixel range.
	always_comb begin
		sum     = SW'(part_s2[0]) + SW'(part_s2[1]) + SW'(part_s2[2]);
		rounded = sum + RND;
		shifted = rounded >>> WEIGHT_FRACTION_BITS;
		if (shifted > PMAX) begin
			sat = PMAX;
		end else if (shifted < PMIN) begin
			sat = PMIN;
		end else begin
			sat = shifted;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign column      = column_q;
	assign line        = line_q;
	assign last_of_run = ctl_q.last_of_run;
	assign frame_end   = ctl_q.frame_end;

endmodule

### rtl/conv3x3_replicate_border.sv
// ----------------------------------------------------------------------------
// conv3x3_replicate_border: streaming 3x3 convolution, replicated borders
// Source pixels enter in raster order; filtered pixels leave with their
// output column and row.
// ----------------------------------------------------------------------------
// Usage: configure sizes and weights through cfg_we/cfg_index/cfg_data while
// the block is idle; writing the source width or height restarts the frame.
// Pixels enter on in_valid/in_ready, one request per clock while in_ready
// is high. Each pixel completes zero to four output pixels; an interior
// pixel completes one. The front end hands one filter job per non-full
// cycle to a four-entry queue, so a pixel that completes more than one output
// holds in_ready low until its last job is handed over (edges of the frame
// only). The filter pipe takes one job per cycle while its output can move.
// With a result presented and out_ready low, the result register holds, the
// filter pipe stops, the queue fills and then in_ready drops; nothing is lost.
// Reset clears the raster position, the window, the queue and the filter
// valid bits, and loads the register defaults. The line stores are not
// cleared; entries not yet written only feed taps the border clamp drops.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border #(
	parameter int MAX_WIDTH            = 1024,
	parameter int PIXEL_BITS           = 16,
	parameter int WEIGHT_FRACTION_BITS = 14,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [c3rb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [c3rb_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [PIXEL_BITS-1:0]                 sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [PIXEL_BITS-1:0]                 value,
	output logic [CW-1:0]                         column,
	output logic [c3rb_pkg::ROW_BITS-1:0]         line,
	output logic                                  last_of_run,
	output logic                                  frame_end
);

	localparam int HB = c3rb_pkg::HEIGHT_BITS;
	localparam int RB = c3rb_pkg::ROW_BITS;
	localparam int JW = c3rb_pkg::TAPS*PIXEL_BITS + CW + RB + $bits(c3rb_pkg::job_ctl_t);

	logic [c3rb_pkg::SRC_WIDTH_BITS-1:0]  src_w_q, out_w_q;
	logic [c3rb_pkg::SRC_HEIGHT_BITS-1:0] src_h_q, out_h_q;
	logic [c3rb_pkg::CFG_DATA_BITS-1:0]   wt_top_q, wt_mid_q;
	logic [c3rb_pkg::WEIGHT_BITS-1:0]     wt_last_q;

	logic [CW:0]  eff_width, out_width;
	logic [HB-1:0] eff_height, out_height;
	logic restart;

	logic fifo_full, fifo_empty, push, pop;
	logic [c3rb_pkg::TAPS*PIXEL_BITS-1:0] f_taps, b_taps;
	logic [CW-1:0] f_col, b_col;
	logic [RB-1:0] f_line, b_line;
	c3rb_pkg::job_ctl_t f_ctl, b_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q   <= c3rb_pkg::RST_SOURCE_WIDTH;
			src_h_q   <= c3rb_pkg::RST_SOURCE_HEIGHT;
			out_w_q   <= c3rb_pkg::RST_OUTPUT_WIDTH;
			out_h_q   <= c3rb_pkg::RST_OUTPUT_HEIGHT;
			wt_top_q  <= c3rb_pkg::RST_WEIGHTS_TOP;
			wt_mid_q  <= c3rb_pkg::RST_WEIGHTS_MID;
			wt_last_q <= c3rb_pkg::RST_WEIGHT_LAST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				c3rb_pkg::REG_SOURCE_WIDTH:   src_w_q   <= cfg_data[c3rb_pkg::SRC_WIDTH_BITS-1:0];
				c3rb_pkg::REG_SOURCE_HEIGHT:  src_h_q   <= cfg_data[c3rb_pkg::SRC_HEIGHT_BITS-1:0];
				c3rb_pkg::REG_OUTPUT_WIDTH:   out_w_q   <= cfg_data[c3rb_pkg::SRC_WIDTH_BITS-1:0];
				c3rb_pkg::REG_OUTPUT_HEIGHT:  out_h_q   <= cfg_data[c3rb_pkg::SRC_HEIGHT_BITS-1:0];
				c3rb_pkg::REG_WEIGHTS_TOP:    wt_top_q  <= cfg_data;
				c3rb_pkg::REG_WEIGHTS_MIDDLE: wt_mid_q  <= cfg_data;
				c3rb_pkg::REG_WEIGHT_LAST:    wt_last_q <= cfg_data[c3rb_pkg::WEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && (cfg_index == c3rb_pkg::REG_SOURCE_WIDTH ||
		cfg_index == c3rb_pkg::REG_SOURCE_HEIGHT);

	// Effective sizes: zero acts as one, the source is capped at the store
	// depth and row limit, and the output is capped at the source.
	always_comb begin
		if (src_w_q == '0) begin
			eff_width = (CW+1)'(1);
		end else if (32'(src_w_q) > 32'(MAX_WIDTH)) begin
			eff_width = (CW+1)'(MAX_WIDTH);
		end else begin
			eff_width = (CW+1)'(src_w_q);
		end
		if (src_h_q == '0) begin
			eff_height = HB'(1);
		end else if (32'(src_h_q) > 32'(c3rb_pkg::ROW_LIMIT)) begin
			eff_height = HB'(c3rb_pkg::ROW_LIMIT);
		end else begin
			eff_height = src_h_q;
		end
		out_width  = (32'(out_w_q) > 32'(eff_width)) ? eff_width : (CW+1)'(out_w_q);
		out_height = (out_h_q > eff_height) ? eff_height : out_h_q;
	end

	c3rb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.eff_width  (eff_width),
		.eff_height (eff_height),
		.out_width  (out_width),
		.out_height (out_height),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.fifo_full  (fifo_full),
		.push       (push),
		.job_taps   (f_taps),
		.job_column (f_col),
		.job_line   (f_line),
		.job_ctl    (f_ctl)
	);

	c3rb_fifo #(
		.WIDTH (JW),
		.DEPTH (4)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_ctl, f_line, f_col, f_taps}),
		.full      (fifo_full),
		.pop       (pop),
		.pop_data  ({b_ctl, b_line, b_col, b_taps}),
		.empty     (fifo_empty)
	);

	c3rb_back #(
		.MAX_WIDTH            (MAX_WIDTH),
		.PIXEL_BITS           (PIXEL_BITS),
		.WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.weights     ({wt_last_q, wt_mid_q, wt_top_q}),
		.fifo_empty  (fifo_empty),
		.pop         (pop),
		.job_taps    (b_taps),
		.job_column  (b_col),
		.job_line    (b_line),
		.job_ctl     (b_ctl),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.column      (column),
		.line        (line),
		.last_of_run (last_of_run),
		.frame_end   (frame_end)
	);

endmodule
